@@ hdl/sipf_pkg.sv @@
// ----------------------------------------------------------------------------
// sipf_pkg
// shared types and constants of the servo instruction packet framer
// ----------------------------------------------------------------------------
package sipf_pkg;

  // item kinds
  localparam logic KindStart = 1'b0;
  localparam logic KindParam = 1'b1;

  // header byte sent twice at the head of every packet
  localparam logic [7:0] HdrByte = 8'hff;

  // smallest length field that opens a frame with parameters
  localparam logic [7:0] MinOpenLen = 8'd3;

  // default depth of the command queue between front and back
  localparam int unsigned QueueDepthDef = 4;

  typedef struct packed {
    logic       kind;
    logic [7:0] servo_id;
    logic [7:0] length;
    logic [7:0] instruction;
    logic [7:0] param_byte;
  } sipf_in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
  } sipf_out_t;

  // one classified request handed from the front to the back
  typedef struct packed {
    logic       kind;      // start or parameter
    logic [7:0] byte0;     // servo id, or the parameter byte
    logic [7:0] byte1;     // length
    logic [7:0] byte2;     // instruction
    logic [7:0] chk;       // inverted running sum
    logic       with_chk;  // checksum closes this request
  } sipf_cmd_t;

endpackage

@@ hdl/sipf_front.sv @@
// ----------------------------------------------------------------------------
// sipf_front
// accepts requests, tracks the open frame and the running sum, and queues
// one command for each request that produces bytes
// ----------------------------------------------------------------------------
module sipf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sipf_pkg::sipf_in_t  in_data_i,
  output logic                push_o,
  output sipf_pkg::sipf_cmd_t push_cmd_o,
  input  logic                full_i
);

  logic       frame_open_q, frame_open_d;
  logic [7:0] remaining_q, remaining_d;
  logic [7:0] sum_q, sum_d;
  logic       accept;
  logic [7:0] rem_dec;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign rem_dec    = remaining_q - 8'd1;

  always_comb begin
    frame_open_d = frame_open_q;
    remaining_d  = remaining_q;
    sum_d        = sum_q;
    push_o       = 1'b0;
    push_cmd_o.kind     = in_data_i.kind;
    push_cmd_o.byte0    = in_data_i.servo_id;
    push_cmd_o.byte1    = in_data_i.length;
    push_cmd_o.byte2    = in_data_i.instruction;
    push_cmd_o.with_chk = 1'b0;
    if (accept) begin
      if (in_data_i.kind == sipf_pkg::KindStart) begin
        // a start abandons any open frame
        push_o = 1'b1;
        sum_d  = in_data_i.servo_id + in_data_i.length + in_data_i.instruction;
        if (in_data_i.length < sipf_pkg::MinOpenLen) begin
          push_cmd_o.with_chk = 1'b1;
          frame_open_d        = 1'b0;
          remaining_d         = 8'd0;
        end else begin
          frame_open_d = 1'b1;
          remaining_d  = in_data_i.length - 8'd2;
        end
      end else if (frame_open_q) begin
        push_o           = 1'b1;
        push_cmd_o.byte0 = in_data_i.param_byte;
        sum_d            = sum_q + in_data_i.param_byte;
        remaining_d      = rem_dec;
        if (rem_dec == 8'd0) begin
          push_cmd_o.with_chk = 1'b1;
          frame_open_d        = 1'b0;
        end
      end
      // stray parameter bytes fall through with no command
    end
    push_cmd_o.chk = ~sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
      remaining_q  <= 8'd0;
      sum_q        <= 8'd0;
    end else begin
      frame_open_q <= frame_open_d;
      remaining_q  <= remaining_d;
      sum_q        <= sum_d;
    end
  end

  // an open frame always still expects at least one parameter
  a_open_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_open_q == (remaining_q != 8'd0))
    else $error("frame open flag and parameter count disagree");

endmodule

@@ hdl/sipf_queue.sv @@
// ----------------------------------------------------------------------------
// sipf_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module sipf_queue #(
  parameter int unsigned Depth = sipf_pkg::QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sipf_pkg::sipf_cmd_t push_cmd_i,
  output logic                full_o,
  output logic                head_valid_o,
  output sipf_pkg::sipf_cmd_t head_cmd_o,
  input  logic                pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sipf_pkg::sipf_cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_cmd_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("command pushed into a full queue");

endmodule

@@ hdl/sipf_back.sv @@
// ----------------------------------------------------------------------------
// sipf_back
// serializes each queued command into packet bytes through an output register
// ----------------------------------------------------------------------------
module sipf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  sipf_pkg::sipf_cmd_t head_cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sipf_pkg::sipf_out_t out_data_o
);

  // byte positions within a start command
  localparam logic [2:0] BeatHdr0 = 3'd0;
  localparam logic [2:0] BeatHdr1 = 3'd1;
  localparam logic [2:0] BeatId   = 3'd2;
  localparam logic [2:0] BeatLen  = 3'd3;
  localparam logic [2:0] BeatIns  = 3'd4;
  localparam logic [2:0] BeatChk  = 3'd5;
  // byte positions within a parameter command
  localparam logic [2:0] BeatPar  = 3'd0;
  localparam logic [2:0] BeatPChk = 3'd1;

  logic [2:0]          beat_q, beat_d;
  logic                out_valid_q, out_valid_d;
  sipf_pkg::sipf_out_t out_q, out_d;
  logic                advance, emit, final_beat;

  assign advance = !out_valid_q || !out_stall_i;
  assign emit    = advance && head_valid_i;

  always_comb begin
    out_d.tx_byte = head_cmd_i.byte0;
    out_d.last    = 1'b0;
    final_beat    = 1'b0;
    if (head_cmd_i.kind == sipf_pkg::KindStart) begin
      case (beat_q)
        BeatHdr0: out_d.tx_byte = sipf_pkg::HdrByte;
        BeatHdr1: out_d.tx_byte = sipf_pkg::HdrByte;
        BeatId:   out_d.tx_byte = head_cmd_i.byte0;
        BeatLen:  out_d.tx_byte = head_cmd_i.byte1;
        BeatIns: begin
          out_d.tx_byte = head_cmd_i.byte2;
          final_beat    = !head_cmd_i.with_chk;
        end
        default: begin
          out_d.tx_byte = head_cmd_i.chk;
          out_d.last    = 1'b1;
          final_beat    = 1'b1;
        end
      endcase
    end else begin
      case (beat_q)
        BeatPar: begin
          out_d.tx_byte = head_cmd_i.byte0;
          final_beat    = !head_cmd_i.with_chk;
        end
        default: begin
          out_d.tx_byte = head_cmd_i.chk;
          out_d.last    = 1'b1;
          final_beat    = 1'b1;
        end
      endcase
    end
  end

  assign pop_o = emit && final_beat;

  always_comb begin
    beat_d      = beat_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = head_valid_i;
    end
    if (emit) begin
      beat_d = final_beat ? BeatHdr0 : beat_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q      <= BeatHdr0;
      out_valid_q <= 1'b0;
    end else begin
      beat_q      <= beat_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a command stays at the queue head until its final byte enters the output register
  a_mid_command_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat_q != BeatHdr0) |-> head_valid_i)
    else $error("queue head lost in the middle of a command");

  // beat never runs past the checksum of a start or of a parameter
  a_beat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> ((head_cmd_i.kind == sipf_pkg::KindStart) ? (beat_q <= BeatChk)
                                                               : (beat_q <= BeatPChk)))
    else $error("beat position out of range");

endmodule

@@ hdl/servo_instruction_packet_framer.sv @@
// ----------------------------------------------------------------------------
// servo_instruction_packet_framer
// builds servo bus instruction packets as a transmit byte stream
// ----------------------------------------------------------------------------
// A start request emits 0xFF 0xFF, id, length and instruction, and opens a
// frame expecting length - 2 parameter requests; with length below 3 the
// inverted checksum follows at once. Each parameter request in an open frame
// emits its byte, and the last one is followed by the checksum byte, marked
// last. Parameter requests with no open frame are dropped. Input requests are
// taken one per cycle while the command queue (QueueDepth entries) has room;
// the output side sends one byte per cycle while out_stall_i is low, and a
// start request yields 5 or 6 bytes and a parameter request 1 or 2. The
// output serializer sets the sustained rate, and the queue lets the input keep
// flowing while the output is stalled. No clearing pass after reset.
// ----------------------------------------------------------------------------
module servo_instruction_packet_framer #(
  parameter int unsigned QueueDepth = sipf_pkg::QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input requests
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sipf_pkg::sipf_in_t  in_data_i,
  // transmit bytes
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sipf_pkg::sipf_out_t out_data_o
);

  // front to queue
  logic                push;
  sipf_pkg::sipf_cmd_t push_cmd;
  logic                full;
  // queue to back
  logic                head_valid;
  sipf_pkg::sipf_cmd_t head_cmd;
  logic                pop;

  // front: frame tracking and checksum
  sipf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .full_i     (full)
  );

  // decoupling queue
  sipf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd),
    .pop_i        (pop)
  );

  // back: byte serializer with output register
  sipf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_cmd_i   (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

@@ test/servo_instruction_packet_framer_test.sv @@
// ----------------------------------------------------------------------------
// servo_instruction_packet_framer_test
// self-checking bench for the servo bus instruction packet framer
// ----------------------------------------------------------------------------
// Requests go in through a valid/stall channel. Each accepted request runs
// through a behavioral framer that queues the transmit bytes it should cause.
// Every accepted output byte is checked against the oldest queued byte. The
// run has a directed part with the corner cases, then random packet traffic
// under several idle and stall mixes. It ends with a long output hold-off
// that fills the block until it stalls its input.
// ----------------------------------------------------------------------------
module servo_instruction_packet_framer_test;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned HoldCycles  = 400;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  sipf_pkg::sipf_in_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  sipf_pkg::sipf_out_t out_data;

  // idle mix of the current phase, in percent
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  // nonzero asks the receiver for one long hold-off, its length set by this value
  int unsigned hold_len       = 0;

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;

  // behavioral framer state
  logic                frame_open  = 1'b0;
  logic [7:0]          params_left = 8'd0;
  logic [7:0]          frame_sum   = 8'd0;
  sipf_pkg::sipf_out_t tx_expect[$];
  sipf_pkg::sipf_out_t tx_head;

  servo_instruction_packet_framer uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // expected byte stream
  // ---------------------------------------------------------------------------

  task automatic expect_byte(input logic [7:0] b, input logic is_last);
    sipf_pkg::sipf_out_t beat;
    beat.tx_byte = b;
    beat.last    = is_last;
    tx_expect.push_back(beat);
  endtask

  // checksum byte ends the packet and closes the frame
  task automatic close_frame;
    frame_open  = 1'b0;
    params_left = 8'd0;
    expect_byte(~frame_sum, 1'b1);
  endtask

  // queue the bytes one accepted request should produce
  task automatic frame_request(input sipf_pkg::sipf_in_t req);
    if (req.kind == sipf_pkg::KindStart) begin
      // a start always restarts, even over an open frame
      expect_byte(sipf_pkg::HdrByte, 1'b0);
      expect_byte(sipf_pkg::HdrByte, 1'b0);
      expect_byte(req.servo_id, 1'b0);
      expect_byte(req.length, 1'b0);
      expect_byte(req.instruction, 1'b0);
      frame_sum = req.servo_id + req.length + req.instruction;
      if (req.length < sipf_pkg::MinOpenLen) begin
        close_frame();
      end else begin
        frame_open  = 1'b1;
        params_left = req.length - 8'd2;
      end
    end else if (frame_open) begin
      expect_byte(req.param_byte, 1'b0);
      frame_sum   = frame_sum + req.param_byte;
      params_left = params_left - 8'd1;
      if (params_left == 8'd0) begin
        close_frame();
      end
    end
    // a parameter with no open frame is dropped silently
  endtask

  // both channels sampled at the edge, before any update of that edge
  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      frame_request(in_data);
    end
    if (out_valid && !out_stall) begin
      if (tx_expect.size() == 0) begin
        $error("unexpected byte: tx_byte %02h last %b", out_data.tx_byte, out_data.last);
        fail_count++;
      end else begin
        tx_head = tx_expect.pop_front();
        if (out_data.tx_byte !== tx_head.tx_byte) begin
          $error("tx_byte: expected %02h, got %02h", tx_head.tx_byte, out_data.tx_byte);
          fail_count++;
        end
        if (out_data.last !== tx_head.last) begin
          $error("last: expected %b, got %b", tx_head.last, out_data.last);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, or one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else begin
        out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("servo_instruction_packet_framer test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // request helpers
  // ---------------------------------------------------------------------------

  // unused fields carry noise, the block must ignore them
  function automatic sipf_pkg::sipf_in_t start_req(input logic [7:0] id,
                                                   input logic [7:0] len,
                                                   input logic [7:0] ins);
    sipf_pkg::sipf_in_t r;
    r.kind        = sipf_pkg::KindStart;
    r.servo_id    = id;
    r.length      = len;
    r.instruction = ins;
    r.param_byte  = 8'($urandom);
    return r;
  endfunction

  function automatic sipf_pkg::sipf_in_t param_req(input logic [7:0] b);
    sipf_pkg::sipf_in_t r;
    r.kind        = sipf_pkg::KindParam;
    r.servo_id    = 8'($urandom);
    r.length      = 8'($urandom);
    r.instruction = 8'($urandom);
    r.param_byte  = b;
    return r;
  endfunction

  // valid stays high across back-to-back requests; only a gap lowers it
  task automatic send_request(input sipf_pkg::sipf_in_t req);
    while ($urandom_range(99, 0) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // valid drops and the bench waits on the clock first, so the last accepted request has been framed
  task automatic drain_bytes;
    in_valid <= 1'b0;
    @(posedge clk);
    while (tx_expect.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_directed;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    send_request(param_req(8'ha5));                // stray, nothing open after reset
    send_request(start_req(8'h00, 8'h00, 8'h00));  // short lengths: checksum at once
    send_request(start_req(8'hff, 8'h01, 8'hff));
    send_request(start_req(8'hfe, 8'h02, 8'h01));
    send_request(start_req(8'h01, 8'h03, 8'h02));  // single parameter
    send_request(param_req(8'hff));
    send_request(param_req(8'h00));                // stray right after the checksum
    send_request(start_req(8'hfd, 8'h04, 8'h03));  // sum wraps past 8 bits
    send_request(param_req(8'h00));
    send_request(param_req(8'hff));
    send_request(start_req(8'h07, 8'h05, 8'h80));  // abandoned by the next start
    send_request(param_req(8'h55));
    send_request(start_req(8'haa, 8'hff, 8'h55));  // largest length, abandoned too
    send_request(param_req(8'h01));
    send_request(param_req(8'hfe));
    send_request(start_req(8'hff, 8'h03, 8'hff));  // clean packet after the abandons
    send_request(param_req(8'h7f));
    send_request(param_req(8'h80));                // stray again
    drain_bytes();
  endtask

  // mostly whole packets; some cut short, some trailed by strays
  task automatic test_random_traffic(input int unsigned n_req, input int unsigned gap_pct,
                                     input int unsigned stall_pct);
    int unsigned sent;
    int unsigned pick;
    int unsigned n_param;
    logic [7:0]  len;
    sent           = 0;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    while (sent < n_req) begin
      pick = $urandom_range(99, 0);
      if (pick < 2) begin
        len = 8'($urandom_range(40, 11));
      end else if (pick < 14) begin
        len = 8'($urandom_range(2, 0));
      end else begin
        len = 8'($urandom_range(10, 3));
      end
      n_param = (len < sipf_pkg::MinOpenLen) ? 0 : int'(len) - 2;
      pick    = $urandom_range(99, 0);
      if (pick < 10 && n_param > 0) begin
        n_param = $urandom_range(n_param - 1, 0);
      end else if (pick < 18) begin
        n_param = n_param + $urandom_range(3, 1);
      end
      send_request(start_req(8'($urandom), len, 8'($urandom)));
      repeat (n_param) send_request(param_req(8'($urandom)));
      sent += 1 + n_param;
    end
    drain_bytes();
  endtask

  // output held off long enough for the queue to fill and stall the input
  task automatic test_input_backpressure;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_len       = HoldCycles;
    repeat (6) begin
      send_request(start_req(8'($urandom), 8'd6, 8'($urandom)));
      repeat (4) send_request(param_req(8'($urandom)));
    end
    drain_bytes();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_traffic(75, 0, 0);
    test_random_traffic(75, 72, 0);
    test_random_traffic(75, 0, 72);
    test_random_traffic(75, 13, 13);
    test_input_backpressure();

    if (fail_count == 0) begin
      $display("servo_instruction_packet_framer test passed");
    end else begin
      $display("servo_instruction_packet_framer test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/sipf_pkg.sv
hdl/sipf_front.sv
hdl/sipf_queue.sv
hdl/sipf_back.sv
hdl/servo_instruction_packet_framer.sv
test/servo_instruction_packet_framer_test.sv
